[hdl/igcd_pkg.sv]
// Shared types and constants for the central-difference gradient block.
// Used by the front end, the bundle queue, the back end and the top level.
// No dependencies.
package igcd_pkg;

	// Field widths of the ports.
	localparam int PIX_W      = 16;
	localparam int GRAD_W     = 17;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 11;
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Register reset values and limits.
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam int MAX_HEIGHT       = 4096;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_PIXEL_BITS = 16;

	// One pixel can produce up to three results, always in this order.
	localparam int NUM_KINDS = 3;
	localparam int RES_UPPER = 0;  // pixel one row up, same column
	localparam int RES_LEFT  = 1;  // last row, pixel one column left
	localparam int RES_SELF  = 2;  // final pixel of the frame

	// Queue between front and back end.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [GRAD_W-1:0] grad_t;

	// All results caused by one pixel.
	typedef struct packed {
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic [NUM_KINDS-1:0]  kinds;
		grad_t [NUM_KINDS-1:0] gx;
		grad_t [NUM_KINDS-1:0] gy;
	} bundle_t;

endpackage

[hdl/igcd_front.sv]
// Front end: accepts pixels, tracks row and column, holds the two line buffers
// and the three-tap window, and computes every gradient one pixel causes.
// Depends on igcd_pkg.
module igcd_front import igcd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  full,
	output logic                  q_push,
	output bundle_t               q_data,
	input  logic                  q_full
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int GW     = GRAD_W;
	localparam int RST_WD = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	// Line buffers: rows r-1 and r-2.
	pix_t lr_mem [MAX_WIDTH];
	pix_t lo_mem [MAX_WIDTH];

	logic [CW-1:0]    wlast_q, col_q, wlast_new, rd_addr;
	logic [ROW_W-1:0] hlast_q, row_q, hlast_new;
	logic             accept, s1_adv, at_lcol, at_lrow;
	pix_t             pix_in, lr0_q, win1_q, win2_q, prev1_q, prev2_q;

	logic             v_s1, lcol_s1, lrow_s1;
	pix_t             p_s1, lr0_s1, lr_rd_s1, lo_rd_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;

	logic                 first;
	pix_t                 rp0, rp1, rp2;
	logic [GW-1:0]        gx_up, gy_up, gx_lf, gy_lf, gx_sf, gy_sf;
	logic [NUM_KINDS-1:0] kinds;

	assign pix_in  = PIXEL_BITS'(pixel);
	assign at_lcol = (col_q == wlast_q);
	assign at_lrow = (row_q == hlast_q);
	assign rd_addr = at_lcol ? '0 : col_q + CW'(1);

	assign kinds[RES_UPPER] = (row_s1 != '0);
	assign kinds[RES_LEFT]  = lrow_s1 && !first;
	assign kinds[RES_SELF]  = lrow_s1 && lcol_s1;

	// A pixel that causes no result leaves stage one without using the queue.
	assign s1_adv = v_s1 && (!(|kinds) || !q_full);
	assign q_push = v_s1 && (|kinds) && !q_full;
	assign full   = v_s1 && !s1_adv;
	assign accept = push && !full;

	// Register writes are clamped into the supported range and kept as last index.
	always_comb begin
		if (32'(cfg_data[FW_W-1:0]) > 32'(MAX_WIDTH)) begin
			wlast_new = CW'(MAX_WIDTH - 1);
		end else if (cfg_data[FW_W-1:0] < FW_W'(2)) begin
			wlast_new = CW'(1);
		end else begin
			wlast_new = CW'(cfg_data[FW_W-1:0] - FW_W'(1));
		end
		if (cfg_data[FH_W-1:0] > FH_W'(MAX_HEIGHT)) begin
			hlast_new = ROW_W'(MAX_HEIGHT - 1);
		end else if (cfg_data[FH_W-1:0] < FH_W'(2)) begin
			hlast_new = ROW_W'(1);
		end else begin
			hlast_new = ROW_W'(cfg_data[FH_W-1:0] - FH_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= CW'(RST_WD - 1);
			hlast_q <= ROW_W'(FRAME_HEIGHT_RST - 1);
			col_q   <= '0;
			row_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						wlast_q <= wlast_new;
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_FRAME_HEIGHT: begin
						hlast_q <= hlast_new;
						col_q   <= '0;
						row_q   <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (at_lcol) begin
					col_q <= '0;
					row_q <= at_lrow ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// Window over row r-1 at columns c and c+1 of the last pixel processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win1_q <= '0;
			win2_q <= '0;
		end else if (s1_adv) begin
			win1_q <= rp1;
			win2_q <= rp2;
		end
	end

	// Column 0 of the recent row lives in a register too, so that the first
	// pixel of a row needs only one line-buffer read.
	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1    <= pix_in;
			row_s1  <= row_q;
			col_s1  <= col_q;
			lcol_s1 <= at_lcol;
			lrow_s1 <= at_lrow;
			lr0_s1  <= lr0_q;
			if (col_q == '0) begin
				lr0_q <= pix_in;
			end
		end
		if (s1_adv) begin
			prev2_q <= prev1_q;
			prev1_q <= p_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lr_mem[col_q] <= pix_in;
			lr_rd_s1      <= lr_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_rd_s1 <= lo_mem[col_q];
		end
		if (s1_adv) begin
			lo_mem[col_s1] <= rp1;
		end
	end

	always_comb begin
		first = (col_s1 == '0);
		rp0   = first ? '0 : win1_q;
		rp1   = first ? lr0_s1 : win2_q;
		rp2   = lcol_s1 ? '0 : lr_rd_s1;

		if (first) begin
			gx_up = GW'(rp2) - GW'(rp1);
		end else if (lcol_s1) begin
			gx_up = GW'(rp1) - GW'(rp0);
		end else begin
			gx_up = GW'(rp2) - GW'(rp0);
		end
		if (row_s1 == ROW_W'(1)) begin
			gy_up = GW'(p_s1) - GW'(rp1);
		end else begin
			gy_up = GW'(p_s1) - GW'(lo_rd_s1);
		end

		// On the last row the left neighbor's upper pixel is the window's left tap.
		if (col_s1 == CW'(1)) begin
			gx_lf = GW'(p_s1) - GW'(prev1_q);
		end else begin
			gx_lf = GW'(p_s1) - GW'(prev2_q);
		end
		gy_lf = GW'(prev1_q) - GW'(rp0);

		gx_sf = GW'(p_s1) - GW'(prev1_q);
		gy_sf = GW'(p_s1) - GW'(rp1);

		q_data.row           = row_s1;
		q_data.col           = COL_W'(col_s1);
		q_data.kinds         = kinds;
		q_data.gx[RES_UPPER] = $signed(gx_up);
		q_data.gy[RES_UPPER] = $signed(gy_up);
		q_data.gx[RES_LEFT]  = $signed(gx_lf);
		q_data.gy[RES_LEFT]  = $signed(gy_lf);
		q_data.gx[RES_SELF]  = $signed(gx_sf);
		q_data.gy[RES_SELF]  = $signed(gy_sf);
	end

endmodule

[hdl/igcd_fifo.sv]
// Short queue of result bundles between the front end and the back end.
// Depends on igcd_pkg for the bundle type and the depth.
module igcd_fifo import igcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  bundle_t wr_data,
	output logic    full,
	input  logic    rd_en,
	output bundle_t rd_data,
	output logic    empty
);

	bundle_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_wr, do_rd;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[hdl/igcd_back.sv]
// Back end: walks the results of the head bundle in order and presents them
// one at a time through an output register. Depends on igcd_pkg.
module igcd_back import igcd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  bundle_t                 q_data,
	output logic                    q_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [GRAD_W-1:0] grad_x,
	output logic signed [GRAD_W-1:0] grad_y,
	output logic [ROW_W-1:0]        out_row,
	output logic [COL_W-1:0]        out_col,
	output logic                    run_last,
	output logic                    frame_end
);

	logic [NUM_KINDS-1:0] done_q, pend, pick;
	logic                 out_v_q, load, last;
	grad_t                sel_gx, sel_gy, gx_q, gy_q;
	logic [ROW_W-1:0]     sel_row, row_q;
	logic [COL_W-1:0]     sel_col, col_q;
	logic                 sel_fe, rl_q, fe_q;

	assign pend  = q_data.kinds & ~done_q;
	assign load  = !q_empty && (!out_v_q || pop);
	assign last  = ((pend & ~pick) == '0);
	assign q_pop = load && last;

	always_comb begin
		pick    = '0;
		sel_gx  = q_data.gx[RES_SELF];
		sel_gy  = q_data.gy[RES_SELF];
		sel_row = q_data.row;
		sel_col = q_data.col;
		sel_fe  = 1'b1;
		if (pend[RES_UPPER]) begin
			pick[RES_UPPER] = 1'b1;
			sel_gx  = q_data.gx[RES_UPPER];
			sel_gy  = q_data.gy[RES_UPPER];
			sel_row = q_data.row - ROW_W'(1);
			sel_fe  = 1'b0;
		end else if (pend[RES_LEFT]) begin
			pick[RES_LEFT] = 1'b1;
			sel_gx  = q_data.gx[RES_LEFT];
			sel_gy  = q_data.gy[RES_LEFT];
			sel_col = q_data.col - COL_W'(1);
			sel_fe  = 1'b0;
		end else begin
			pick[RES_SELF] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				done_q  <= last ? '0 : (done_q | pick);
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gx_q  <= sel_gx;
			gy_q  <= sel_gy;
			row_q <= sel_row;
			col_q <= sel_col;
			rl_q  <= last;
			fe_q  <= sel_fe;
		end
	end

	assign empty     = !out_v_q;
	assign grad_x    = gx_q;
	assign grad_y    = gy_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign run_last  = rl_q;
	assign frame_end = fe_q;

endmodule

[hdl/image_gradient_central_diff.sv]
// Streaming central-difference image gradient, top level.
// Depends on igcd_pkg, igcd_front, igcd_fifo and igcd_back.
//
// Pixels enter in raster order through push/full, one per clock while full is
// low. An accepted pixel is registered into stage one, then queued; the queue
// head loads the output register. A pixel on row r >= 1 releases the gradient
// of the pixel above it; on the last row each pixel past column 0 also
// releases its left neighbor, and the final pixel of the frame releases its
// own result with frame_end set. Row 0 gives no result. Results leave one per
// clock through empty/pop while pop is held, so inner rows run at one pixel
// per clock; most last-row pixels release two results (the final one three),
// so the single result port holds them back. Gradients are signed integer
// differences with no fractional bit; border pixels use one-sided differences.
// Writing either frame register restarts the frame at row 0, column 0; write
// only when no pixel is in flight. The line buffers are not cleared, so the
// first two rows after power-up may give meaningless values only where the
// frame reads rows it has not yet written.
module image_gradient_central_diff import igcd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    push,
	output logic                    full,
	input  logic [PIX_W-1:0]        pixel,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [GRAD_W-1:0] grad_x,
	output logic signed [GRAD_W-1:0] grad_y,
	output logic [ROW_W-1:0]        out_row,
	output logic [COL_W-1:0]        out_col,
	output logic                    run_last,
	output logic                    frame_end
);

	logic    q_push, q_full, q_pop, q_empty;
	bundle_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	igcd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	igcd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	igcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.grad_x    (grad_x),
		.grad_y    (grad_y),
		.out_row   (out_row),
		.out_col   (out_col),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

endmodule

[tb/sv/gradient_checker.sv]
// Checker for the central-difference gradient block: watches the register,
// pixel and result channels, predicts every result word and compares it.
// Depends on igcd_pkg.
module gradient_checker import igcd_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  logic                  full,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  empty,
	input  logic                  pop,
	input  grad_t                 grad_x,
	input  grad_t                 grad_y,
	input  logic [ROW_W-1:0]      out_row,
	input  logic [COL_W-1:0]      out_col,
	input  logic                  run_last,
	input  logic                  frame_end,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		grad_t            gx;
		grad_t            gy;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
		logic             fend;
	} gradient_word_t;

	logic [PIX_W-1:0]  row_above [MAX_WIDTH];
	logic [PIX_W-1:0]  row_two_up [MAX_WIDTH];
	logic [PIX_W-1:0]  tap_left, tap_mid, tap_right;
	logic [FW_W-1:0]   width_reg;
	logic [FH_W-1:0]   height_reg;
	int                cur_row, cur_col;
	gradient_word_t    expected_words [$];
	gradient_word_t    seen_word, due_word;

	function automatic int clamp_to(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic grad_t pixel_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
		return grad_t'({1'b0, a} - {1'b0, b});
	endfunction

	task automatic apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = value[FW_W-1:0];
		end else if (idx == REG_FRAME_HEIGHT) begin
			height_reg = value[FH_W-1:0];
		end else begin
			return;
		end
		cur_row = 0;
		cur_col = 0;
	endtask

	// Works out every result word one pixel releases and queues them in order.
	task automatic predict_gradients(logic [PIX_W-1:0] p);
		gradient_word_t words [NUM_KINDS];
		int w, h, r, c, n;
		w = clamp_to(width_reg, 2, MAX_WIDTH);
		h = clamp_to(height_reg, 2, MAX_HEIGHT);
		r = cur_row;
		c = cur_col;
		n = 0;

		// Three-tap window along the row above, centered on this column.
		if (c == 0) begin
			tap_left  = '0;
			tap_mid   = row_above[0];
			tap_right = row_above[1];
		end else begin
			tap_left  = tap_mid;
			tap_mid   = tap_right;
			tap_right = (c + 1 < w) ? row_above[c + 1] : '0;
		end

		if (r >= 1) begin
			words[n] = '0;
			if (c == 0)
				words[n].gx = pixel_diff(tap_right, tap_mid);
			else if (c == w - 1)
				words[n].gx = pixel_diff(tap_mid, tap_left);
			else
				words[n].gx = pixel_diff(tap_right, tap_left);
			words[n].gy  = (r == 1) ? pixel_diff(p, tap_mid) : pixel_diff(p, row_two_up[c]);
			words[n].row = ROW_W'(r - 1);
			words[n].col = COL_W'(c);
			n++;
		end

		row_two_up[c] = row_above[c];
		row_above[c]  = p;

		// The last row also flushes its left neighbor, and the final pixel itself.
		if (r == h - 1) begin
			if (c >= 1) begin
				words[n]     = '0;
				words[n].gx  = pixel_diff(p, row_above[(c == 1) ? 0 : c - 2]);
				words[n].gy  = pixel_diff(row_above[c - 1], row_two_up[c - 1]);
				words[n].row = ROW_W'(r);
				words[n].col = COL_W'(c - 1);
				n++;
			end
			if (c == w - 1) begin
				words[n]      = '0;
				words[n].gx   = pixel_diff(p, row_above[c - 1]);
				words[n].gy   = pixel_diff(p, tap_mid);
				words[n].row  = ROW_W'(r);
				words[n].col  = COL_W'(c);
				words[n].fend = 1'b1;
				n++;
			end
		end

		if (n > 0)
			words[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_words.push_back(words[k]);

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		cur_row = r;
		cur_col = c;
	endtask

	task automatic check_field(string name, logic signed [31:0] want,
				   logic signed [31:0] got, int row, int col);
		if (got !== want) begin
			errors++;
			$display("%0t: %s of result (%0d,%0d): expected %0d, got %0d",
				 $time, name, row, col, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = FW_W'(FRAME_WIDTH_RST);
			height_reg = FH_W'(FRAME_HEIGHT_RST);
			cur_row    = 0;
			cur_col    = 0;
			tap_left   = '0;
			tap_mid    = '0;
			tap_right  = '0;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				row_above[i]  = '0;
				row_two_up[i] = '0;
			end
			expected_words.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_config(cfg_index, cfg_data);
			if (push && !full)
				predict_gradients(pixel);
			if (pop && !empty) begin
				seen_word.gx   = grad_x;
				seen_word.gy   = grad_y;
				seen_word.row  = out_row;
				seen_word.col  = out_col;
				seen_word.last = run_last;
				seen_word.fend = frame_end;
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: result word (%0d,%0d) with nothing expected, expected none, got gx %0d gy %0d",
						 $time, out_row, out_col, grad_x, grad_y);
				end else begin
					due_word = expected_words.pop_front();
					check_field("grad_x", due_word.gx, seen_word.gx, due_word.row, due_word.col);
					check_field("grad_y", due_word.gy, seen_word.gy, due_word.row, due_word.col);
					check_field("out_row", due_word.row, seen_word.row, due_word.row, due_word.col);
					check_field("out_col", due_word.col, seen_word.col, due_word.row, due_word.col);
					check_field("run_last", due_word.last, seen_word.last, due_word.row, due_word.col);
					check_field("frame_end", due_word.fend, seen_word.fend, due_word.row, due_word.col);
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
// Top of the gradient testbench: clock, reset, pixel and register stimulus,
// and the verdict. Depends on igcd_pkg, image_gradient_central_diff and
// gradient_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import igcd_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 50;
	localparam int NUM_PHASES    = 4;
	localparam int BIG_ITEMS     = 16;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [PIX_W-1:0]      pixel     = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	grad_t                 grad_x, grad_y;
	logic [ROW_W-1:0]      out_row;
	logic [COL_W-1:0]      out_col;
	logic                  run_last, frame_end;
	int                    errors, pending;

	int gap_pct   = 0;
	int stall_pct = 0;
	int pixels_sent;
	int gap_by_phase [NUM_PHASES]   = '{0, 66, 0, 13};
	int stall_by_phase [NUM_PHASES] = '{0, 0, 66, 13};

	logic [PIX_W-1:0] corner_pixels [9] = '{
		16'h0000, 16'hFFFF, 16'h1234,
		16'hFFFF, 16'h0000, 16'h8000,
		16'h7FFF, 16'hFFFF, 16'h0000
	};

	image_gradient_central_diff DUT (.*);

	gradient_checker grad_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// Push stays high from one word to the next unless a gap is drawn.
	task automatic send_pixel(logic [PIX_W-1:0] value);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= value;
		do @(posedge clk); while (full);
		pixels_sent++;
	endtask

	task automatic send_pixels(int count);
		repeat (count) send_pixel(random_pixel());
	endtask

	// Row 0 releases nothing, so the extra cycles cover pixels still in flight.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		settle();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// Mostly whole frames; some are cut short or preceded by a stray register write.
	task automatic run_random_frame();
		int w, h, pick;
		w    = $urandom_range(9, 2);
		h    = $urandom_range(6, 2);
		pick = $urandom_range(9);
		if (pick < 7) begin
			set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
			send_pixels(w * h * $urandom_range(2, 1));
		end else if (pick < 9) begin
			set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
			send_pixels($urandom_range(w * h - 1, 1));
		end else begin
			settle();
			write_reg(CFG_IDX_W'($urandom), CFG_DATA_W'($urandom));
			send_pixels($urandom_range(30, 1));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 3x3 frame has one interior pixel and every kind of border.
		set_frame(13'd3, 13'd3);
		foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);

		// Sizes below the minimum clamp to 2x2; full-scale steps both ways.
		set_frame(13'd1, 13'd0);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);

		// Writes past the last register must not restart the frame.
		send_pixels(2);
		settle();
		write_reg(CFG_IDX_W'(2), 13'h1FFF);
		write_reg(CFG_IDX_W'(3), 13'h0000);
		send_pixels(2);

		// A width write restarts mid-frame; only the low 12 bits count.
		send_pixels(1);
		settle();
		write_reg(REG_FRAME_WIDTH, 13'h1003);
		send_pixels(6);

		// Oversized registers clamp from above; only the first pixels are sent.
		set_frame(13'd4095, 13'd2);
		send_pixels(BIG_ITEMS);
		set_frame(13'd0, 13'h1FFF);
		send_pixels(BIG_ITEMS);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			gap_pct     = gap_by_phase[phase];
			stall_pct   = stall_by_phase[phase];
			pixels_sent = 0;
			while (pixels_sent < PHASE_ITEMS) run_random_frame();
		end

		settle();
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#4ms;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
